// ===== src/ptsim_pkg.sv =====
// Package with payload types, codes and helpers shared by the particle table files.
package ptsim_pkg;

  localparam logic [1:0] OP_SPAWN = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_BADIDX = 2'd2;

  localparam logic CFG_FADE   = 1'b0;
  localparam logic CFG_FIZZLE = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [23:0]        tick_dt;
    logic signed [31:0] spawn_pos_x;
    logic signed [31:0] spawn_pos_y;
    logic signed [31:0] spawn_vel_x;
    logic signed [31:0] spawn_vel_y;
    logic signed [31:0] spawn_acc_x;
    logic signed [31:0] spawn_acc_y;
    logic [23:0]        spawn_life;
    logic [31:0]        spawn_size;
    logic [7:0]         spawn_alpha;
    logic [7:0]         entry_index;
  } ptsim_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         live_count;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic [23:0]        out_life;
    logic [31:0]        out_size;
    logic [7:0]         out_alpha;
  } ptsim_out_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [23:0]        life;
    logic [31:0]        size;
    logic [7:0]         alpha;
  } ptsim_entry_t;

  typedef struct packed {
    logic        start;
    logic        short_mode;
    logic [55:0] dividend;
    logic [23:0] divisor;
  } ptsim_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } ptsim_div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RDOUT, ST_LOOP, ST_FETCH, ST_CHECK, ST_COPY,
    ST_MUL_AX, ST_ADD_VX, ST_MUL_VX, ST_ADD_PX,
    ST_MUL_AY, ST_ADD_VY, ST_MUL_VY, ST_ADD_PY,
    ST_MUL_AL, ST_DIV_AL, ST_MUL_SZ, ST_DIV_SZ, ST_WRITE, ST_DONE
  } ptsim_state_e;

  // x + floor(p / 2^16), saturated to 32-bit signed
  function automatic logic signed [31:0] sat_add(logic signed [31:0] x,
                                                 logic signed [57:0] p);
    logic signed [57:0] sh;
    logic signed [41:0] s;
    sh = p >>> 16;
    s  = 42'(x) + sh[41:0];
    if (s[41:31] == {11{1'b0}} || s[41:31] == {11{1'b1}}) begin
      return s[31:0];
    end else if (s[41]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

// ===== src/ptsim_div.sv =====
// Restoring divider, one quotient bit per cycle, 8 or 32 quotient bits.
module ptsim_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ptsim_pkg::ptsim_div_req_t req_i,
  output ptsim_pkg::ptsim_div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [23:0] rem_q;
  logic [31:0] bits_q;
  logic [31:0] quot_q;
  logic [24:0] trial;
  logic [24:0] diff;
  logic        ge;

  assign trial = {rem_q, bits_q[31]};
  assign diff  = trial - {1'b0, req_i.divisor};
  assign ge    = trial >= {1'b0, req_i.divisor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == 6'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_mode ? 6'd8 : 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= '0;
      if (req_i.short_mode) begin
        rem_q  <= req_i.dividend[31:8];
        bits_q <= {req_i.dividend[7:0], 24'd0};
      end else begin
        rem_q  <= req_i.dividend[55:32];
        bits_q <= req_i.dividend[31:0];
      end
    end else if (busy_q) begin
      rem_q  <= ge ? diff[23:0] : trial[23:0];
      bits_q <= {bits_q[30:0], 1'b0};
      quot_q <= {quot_q[30:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== src/particle_table_simulate.sv =====
// Particle table with spawn, read and a fixed-point Euler tick over a single entry memory.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o  | in_data_i (ptsim_in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (ptsim_out_t)
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One transaction at a time. A tick visits each entry in turn; fade and fizzle each add a
// pass through the serial divider for every kept entry, and a removed entry is replaced
// by the last one. The entry memory has one read and one write port.
// Reset clears the count and the control registers only; the memory needs no clearing.
// A waiting result holds the block until it is taken.
module particle_table_simulate #(
  parameter int NUM_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ptsim_pkg::ptsim_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ptsim_pkg::ptsim_out_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic                  cfg_data_i
);

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(NUM_ENTRIES);

  ptsim_pkg::ptsim_entry_t mem [NUM_ENTRIES];
  ptsim_pkg::ptsim_entry_t rdata_q, wdata_c, e_q;
  logic          we_c, re_c;
  logic [AW-1:0] waddr_c, raddr_c;

  ptsim_pkg::ptsim_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, i_q, last_c;
  logic [1:0]    op_q;
  logic [23:0]   dt_q;
  logic          fade_q, fizzle_q, div_run_q, out_valid_q;
  logic signed [57:0] prod_q;
  logic signed [57:0] prod_c;
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  ptsim_pkg::ptsim_out_t res_q, out_q;
  ptsim_pkg::ptsim_div_req_t div_req;
  ptsim_pkg::ptsim_div_rsp_t div_rsp;
  logic          accept, out_free;
  logic [12:0]   idx_ext;
  logic          spawn_full, read_bad;

  assign accept     = in_valid_i && (state_q == ptsim_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_c     = cnt_q - CW'(1);
  assign idx_ext    = {5'd0, in_data_i.entry_index};
  assign prod_c     = mul_a * mul_b;
  assign spawn_full = (in_data_i.opcode == ptsim_pkg::OP_SPAWN) && (cnt_q >= MaxCnt);
  assign read_bad   = (in_data_i.opcode == ptsim_pkg::OP_READ) &&
                      (32'(idx_ext) >= 32'(cnt_q));

  ptsim_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req.start      = ((state_q == ptsim_pkg::ST_DIV_AL) ||
                          (state_q == ptsim_pkg::ST_DIV_SZ)) && !div_run_q;
    div_req.short_mode = (state_q == ptsim_pkg::ST_DIV_AL);
    div_req.dividend   = (state_q == ptsim_pkg::ST_DIV_SZ) ? prod_q[55:0]
                                                           : {24'd0, prod_q[31:0]};
    div_req.divisor    = e_q.life;
  end

  always_comb begin
    mul_a = 33'(e_q.acc_x);
    mul_b = $signed({1'b0, dt_q});
    unique case (state_q)
      ptsim_pkg::ST_MUL_VX: mul_a = 33'(e_q.vel_x);
      ptsim_pkg::ST_MUL_AY: mul_a = 33'(e_q.acc_y);
      ptsim_pkg::ST_MUL_VY: mul_a = 33'(e_q.vel_y);
      ptsim_pkg::ST_MUL_AL: mul_a = $signed({25'd0, e_q.alpha});
      ptsim_pkg::ST_MUL_SZ: begin
        mul_a = $signed({1'b0, e_q.size});
        mul_b = $signed({1'b0, e_q.life - dt_q});
      end
      default: mul_a = 33'(e_q.acc_x);
    endcase
  end

  always_comb begin
    state_d = state_q;
    we_c    = 1'b0;
    re_c    = 1'b0;
    waddr_c = i_q[AW-1:0];
    raddr_c = i_q[AW-1:0];
    wdata_c = e_q;
    unique case (state_q)
      ptsim_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = ptsim_pkg::ST_DONE;
          if (in_data_i.opcode == ptsim_pkg::OP_SPAWN && cnt_q < MaxCnt) begin
            we_c          = 1'b1;
            waddr_c       = cnt_q[AW-1:0];
            wdata_c.pos_x = in_data_i.spawn_pos_x;
            wdata_c.pos_y = in_data_i.spawn_pos_y;
            wdata_c.vel_x = in_data_i.spawn_vel_x;
            wdata_c.vel_y = in_data_i.spawn_vel_y;
            wdata_c.acc_x = in_data_i.spawn_acc_x;
            wdata_c.acc_y = in_data_i.spawn_acc_y;
            wdata_c.life  = in_data_i.spawn_life;
            wdata_c.size  = in_data_i.spawn_size;
            wdata_c.alpha = in_data_i.spawn_alpha;
          end else if (in_data_i.opcode == ptsim_pkg::OP_TICK) begin
            state_d = ptsim_pkg::ST_LOOP;
          end else if (in_data_i.opcode == ptsim_pkg::OP_READ &&
                       32'(idx_ext) < 32'(cnt_q)) begin
            re_c    = 1'b1;
            raddr_c = idx_ext[AW-1:0];
            state_d = ptsim_pkg::ST_RDOUT;
          end
        end
      end
      ptsim_pkg::ST_RDOUT: state_d = ptsim_pkg::ST_DONE;
      ptsim_pkg::ST_LOOP: begin
        if (i_q < cnt_q) begin
          re_c    = 1'b1;
          state_d = ptsim_pkg::ST_FETCH;
        end else begin
          state_d = ptsim_pkg::ST_DONE;
        end
      end
      ptsim_pkg::ST_FETCH: state_d = ptsim_pkg::ST_CHECK;
      ptsim_pkg::ST_CHECK: begin
        if (e_q.life <= dt_q) begin
          re_c    = 1'b1;
          raddr_c = last_c[AW-1:0];
          state_d = ptsim_pkg::ST_COPY;
        end else begin
          state_d = ptsim_pkg::ST_MUL_AX;
        end
      end
      ptsim_pkg::ST_COPY: begin
        we_c    = 1'b1;
        wdata_c = rdata_q;
        state_d = ptsim_pkg::ST_LOOP;
      end
      ptsim_pkg::ST_MUL_AX: state_d = ptsim_pkg::ST_ADD_VX;
      ptsim_pkg::ST_ADD_VX: state_d = ptsim_pkg::ST_MUL_VX;
      ptsim_pkg::ST_MUL_VX: state_d = ptsim_pkg::ST_ADD_PX;
      ptsim_pkg::ST_ADD_PX: state_d = ptsim_pkg::ST_MUL_AY;
      ptsim_pkg::ST_MUL_AY: state_d = ptsim_pkg::ST_ADD_VY;
      ptsim_pkg::ST_ADD_VY: state_d = ptsim_pkg::ST_MUL_VY;
      ptsim_pkg::ST_MUL_VY: state_d = ptsim_pkg::ST_ADD_PY;
      ptsim_pkg::ST_ADD_PY: begin
        priority if (fade_q) state_d = ptsim_pkg::ST_MUL_AL;
        else if (fizzle_q) state_d = ptsim_pkg::ST_MUL_SZ;
        else state_d = ptsim_pkg::ST_WRITE;
      end
      ptsim_pkg::ST_MUL_AL: state_d = ptsim_pkg::ST_DIV_AL;
      ptsim_pkg::ST_DIV_AL: begin
        if (div_rsp.done) begin
          state_d = fizzle_q ? ptsim_pkg::ST_MUL_SZ : ptsim_pkg::ST_WRITE;
        end
      end
      ptsim_pkg::ST_MUL_SZ: state_d = ptsim_pkg::ST_DIV_SZ;
      ptsim_pkg::ST_DIV_SZ: begin
        if (div_rsp.done) state_d = ptsim_pkg::ST_WRITE;
      end
      ptsim_pkg::ST_WRITE: begin
        we_c         = 1'b1;
        wdata_c.life = e_q.life - dt_q;
        state_d      = ptsim_pkg::ST_LOOP;
      end
      ptsim_pkg::ST_DONE: begin
        if (out_free) state_d = ptsim_pkg::ST_IDLE;
      end
      default: state_d = ptsim_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c) mem[waddr_c] <= wdata_c;
    if (re_c) rdata_q <= mem[raddr_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptsim_pkg::ST_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      fade_q      <= 1'b0;
      fizzle_q    <= 1'b0;
      div_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == ptsim_pkg::CFG_FADE) fade_q <= cfg_data_i;
        if (cfg_index_i == ptsim_pkg::CFG_FIZZLE) fizzle_q <= cfg_data_i;
      end
      if (accept) i_q <= '0;
      if (state_q == ptsim_pkg::ST_IDLE && we_c) cnt_q <= cnt_q + CW'(1);
      if (state_q == ptsim_pkg::ST_COPY) cnt_q <= last_c;
      if (state_q == ptsim_pkg::ST_WRITE) i_q <= i_q + CW'(1);
      if (div_req.start) div_run_q <= 1'b1;
      else if (div_rsp.done) div_run_q <= 1'b0;
      if (state_q == ptsim_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q             <= in_data_i.opcode;
      dt_q             <= in_data_i.tick_dt;
      res_q.live_count <= '0;
      res_q.status     <= spawn_full ? ptsim_pkg::STAT_FULL :
                          read_bad   ? ptsim_pkg::STAT_BADIDX : ptsim_pkg::STAT_OK;
      res_q.out_pos_x  <= '0;
      res_q.out_pos_y  <= '0;
      res_q.out_life   <= '0;
      res_q.out_size   <= '0;
      res_q.out_alpha  <= '0;
    end
    if (state_q == ptsim_pkg::ST_RDOUT && op_q == ptsim_pkg::OP_READ) begin
      res_q.out_pos_x <= rdata_q.pos_x;
      res_q.out_pos_y <= rdata_q.pos_y;
      res_q.out_life  <= rdata_q.life;
      res_q.out_size  <= rdata_q.size;
      res_q.out_alpha <= rdata_q.alpha;
    end
    prod_q <= prod_c;
    unique case (state_q)
      ptsim_pkg::ST_FETCH:  e_q <= rdata_q;
      ptsim_pkg::ST_ADD_VX: e_q.vel_x <= ptsim_pkg::sat_add(e_q.vel_x, prod_q);
      ptsim_pkg::ST_ADD_PX: e_q.pos_x <= ptsim_pkg::sat_add(e_q.pos_x, prod_q);
      ptsim_pkg::ST_ADD_VY: e_q.vel_y <= ptsim_pkg::sat_add(e_q.vel_y, prod_q);
      ptsim_pkg::ST_ADD_PY: e_q.pos_y <= ptsim_pkg::sat_add(e_q.pos_y, prod_q);
      ptsim_pkg::ST_DIV_AL: if (div_rsp.done) e_q.alpha <= e_q.alpha - div_rsp.quot[7:0];
      ptsim_pkg::ST_DIV_SZ: if (div_rsp.done) e_q.size <= div_rsp.quot;
      default: ;
    endcase
    if (state_q == ptsim_pkg::ST_DONE && out_free) begin
      out_q.status     <= res_q.status;
      out_q.live_count <= 9'(cnt_q);
      out_q.out_pos_x  <= res_q.out_pos_x;
      out_q.out_pos_y  <= res_q.out_pos_y;
      out_q.out_life   <= res_q.out_life;
      out_q.out_size   <= res_q.out_size;
      out_q.out_alpha  <= res_q.out_alpha;
    end
  end

  assign in_stall_o  = (state_q != ptsim_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/ptsim_checker.sv =====
// Checker for the particle table: watches the input, output and config channels, predicts each result and compares it.
module ptsim_checker
  import ptsim_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  ptsim_in_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  ptsim_out_t out_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic       cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         live_o
);

  ptsim_entry_t particles [256];
  int           live_count;
  logic         fade_on;
  logic         fizzle_on;
  ptsim_out_t   expected_q [$];

  function automatic logic signed [31:0] integrate_sat(logic signed [31:0] x,
                                                       logic signed [31:0] rate,
                                                       logic [23:0] dt);
    longint prod;
    longint sum;
    prod = longint'(rate) * longint'({8'd0, dt});
    sum  = longint'(x) + (prod >>> 16);
    if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
    if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
    return sum[31:0];
  endfunction

  function automatic void age_particles(logic [23:0] dt);
    int i;
    longint unsigned q;
    ptsim_entry_t e;
    i = 0;
    while (i < live_count) begin
      e = particles[i];
      if (e.life <= dt) begin
        particles[i] = particles[live_count - 1];
        live_count--;
      end else begin
        e.vel_x = integrate_sat(e.vel_x, e.acc_x, dt);
        e.pos_x = integrate_sat(e.pos_x, e.vel_x, dt);
        e.vel_y = integrate_sat(e.vel_y, e.acc_y, dt);
        e.pos_y = integrate_sat(e.pos_y, e.vel_y, dt);
        if (fade_on) begin
          q = (longint'(e.alpha) * longint'(dt)) / longint'(e.life);
          e.alpha = e.alpha - q[7:0];
        end
        if (fizzle_on) begin
          q = (longint'(e.size) * longint'(e.life - dt)) / longint'(e.life);
          e.size = q[31:0];
        end
        e.life = e.life - dt;
        particles[i] = e;
        i++;
      end
    end
  endfunction

  function automatic ptsim_out_t predict_result(ptsim_in_t it);
    ptsim_out_t r;
    ptsim_entry_t e;
    r = '0;
    r.status = STAT_OK;
    case (it.opcode)
      OP_SPAWN: begin
        if (live_count >= 256) begin
          r.status = STAT_FULL;
        end else begin
          e.pos_x = it.spawn_pos_x;
          e.pos_y = it.spawn_pos_y;
          e.vel_x = it.spawn_vel_x;
          e.vel_y = it.spawn_vel_y;
          e.acc_x = it.spawn_acc_x;
          e.acc_y = it.spawn_acc_y;
          e.life  = it.spawn_life;
          e.size  = it.spawn_size;
          e.alpha = it.spawn_alpha;
          particles[live_count] = e;
          live_count++;
        end
      end
      OP_TICK: age_particles(it.tick_dt);
      OP_READ: begin
        if (int'(it.entry_index) >= live_count) begin
          r.status = STAT_BADIDX;
        end else begin
          e = particles[it.entry_index];
          r.out_pos_x = e.pos_x;
          r.out_pos_y = e.pos_y;
          r.out_life  = e.life;
          r.out_size  = e.size;
          r.out_alpha = e.alpha;
        end
      end
      default: ;
    endcase
    r.live_count = live_count[8:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ptsim_out_t exp_r;
    if (!rst_ni) begin
      live_count = 0;
      fade_on = 1'b0;
      fizzle_on = 1'b0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", out_data_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data_i.status !== exp_r.status ||
              out_data_i.live_count !== exp_r.live_count ||
              out_data_i.out_pos_x !== exp_r.out_pos_x ||
              out_data_i.out_pos_y !== exp_r.out_pos_y ||
              out_data_i.out_life !== exp_r.out_life ||
              out_data_i.out_size !== exp_r.out_size ||
              out_data_i.out_alpha !== exp_r.out_alpha) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch: expected st=%0d cnt=%0d px=%h py=%h life=%h size=%h a=%h",
                       exp_r.status, exp_r.live_count, exp_r.out_pos_x, exp_r.out_pos_y,
                       exp_r.out_life, exp_r.out_size, exp_r.out_alpha);
              $display("          actual   st=%0d cnt=%0d px=%h py=%h life=%h size=%h a=%h",
                       out_data_i.status, out_data_i.live_count, out_data_i.out_pos_x,
                       out_data_i.out_pos_y, out_data_i.out_life, out_data_i.out_size,
                       out_data_i.out_alpha);
            end
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FADE) fade_on = cfg_data_i;
        else fizzle_on = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result(in_data_i));
    end
    pending_o = expected_q.size();
    live_o = live_count;
  end

endmodule

// ===== verif/tb_particle_table_simulate.sv =====
// Testbench top for the particle table: stimulus, flow control and the verdict.
module tb_particle_table_simulate;
  import ptsim_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  ptsim_in_t  in_data;
  logic       out_valid;
  logic       out_stall;
  ptsim_out_t out_data;
  logic       cfg_we;
  logic       cfg_index;
  logic       cfg_data;
  int         fail_count;
  int         pending;
  int         live;
  int         idle_pct;
  int         stall_pct;

  particle_table_simulate dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ptsim_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .live_o(live)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(ptsim_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic ptsim_in_t spawn_item(logic signed [31:0] p, logic signed [31:0] v,
                                           logic signed [31:0] a, logic [23:0] life,
                                           logic [31:0] sz, logic [7:0] al);
    ptsim_in_t it;
    it = ptsim_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom});
    it.opcode = OP_SPAWN;
    it.spawn_pos_x = p;
    it.spawn_pos_y = ~p;
    it.spawn_vel_x = v;
    it.spawn_vel_y = ~v;
    it.spawn_acc_x = a;
    it.spawn_acc_y = ~a;
    it.spawn_life  = life;
    it.spawn_size  = sz;
    it.spawn_alpha = al;
    return it;
  endfunction

  function automatic ptsim_in_t op_item(logic [1:0] op, logic [23:0] dt, logic [7:0] idx);
    ptsim_in_t it;
    it = ptsim_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom});
    it.opcode      = op;
    it.tick_dt     = dt;
    it.entry_index = idx;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_motion();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(200_000)) - 100_000;
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(20_000_000)) - 10_000_000;
    endcase
  endfunction

  function automatic ptsim_in_t random_item(int count);
    int pick;
    logic [23:0] life;
    pick = $urandom_range(99);
    if (count > 12 && pick < 40) pick = 50;
    if (pick < 40) begin
      life = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h60000));
      return spawn_item(rand_motion(), rand_motion(), rand_motion(), life,
                        $urandom, 8'($urandom));
    end else if (pick < 65) begin
      return op_item(OP_TICK, ($urandom_range(9) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(24'h30000)),
                     8'($urandom));
    end else if (pick < 95) begin
      return op_item(OP_READ, 24'($urandom),
                     (count > 0 && $urandom_range(4) != 0) ? 8'($urandom_range(count - 1))
                                                          : 8'($urandom));
    end else begin
      return op_item(2'd3, 24'($urandom), 8'($urandom));
    end
  endfunction

  initial begin
    int phase;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_FADE;
    cfg_data  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    rst_n     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_cfg(CFG_FADE, 1'b1);
    write_cfg(CFG_FIZZLE, 1'b1);
    send_item(op_item(OP_READ, 24'hFFFFFF, 8'd0));
    send_item(op_item(OP_TICK, 24'h010000, 8'd0));
    send_item(spawn_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFFFFFF,
                         32'hFFFF_FFFF, 8'hFF));
    send_item(spawn_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'h000001,
                         32'h0, 8'h0));
    send_item(spawn_item(32'sh0001_0000, -32'sh0000_8000, 32'sh0002_0000, 24'h000000,
                         32'h0010_0000, 8'h80));
    send_item(spawn_item(32'sh0, 32'sh0001_0000, -32'sh0001_0000, 24'h020000,
                         32'h0001_0000, 8'hAA));
    send_item(op_item(OP_READ, 24'h0, 8'd0));
    send_item(op_item(OP_READ, 24'h0, 8'd3));
    send_item(op_item(OP_READ, 24'h0, 8'd4));
    send_item(op_item(OP_READ, 24'h0, 8'hFF));
    send_item(op_item(2'd3, 24'hFFFFFF, 8'hFF));
    send_item(op_item(OP_TICK, 24'h000000, 8'd0));
    send_item(op_item(OP_READ, 24'h0, 8'd2));
    send_item(op_item(OP_TICK, 24'h00FFFF, 8'd0));
    send_item(op_item(OP_READ, 24'h0, 8'd0));
    send_item(op_item(OP_READ, 24'h0, 8'd1));
    send_item(op_item(OP_TICK, 24'hFFFFFF, 8'd0));
    send_item(op_item(OP_READ, 24'h0, 8'd0));
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      write_cfg(CFG_FADE, phase[0]);
      write_cfg(CFG_FIZZLE, phase[1] ^ phase[0]);
      for (int n = 0; n < 7; n++) begin
        if (n == 3 && phase == 1) while (pending != 0) @(negedge clk);
        send_item(random_item(live));
      end
      drain();
    end

    // fill the table to its limit, then age and empty it
    idle_pct  = 0;
    stall_pct = 30;
    write_cfg(CFG_FADE, 1'b1);
    write_cfg(CFG_FIZZLE, 1'b0);
    while (live < 256) begin
      send_item(spawn_item(rand_motion(), rand_motion(), rand_motion(),
                           24'($urandom_range(24'h10000, 24'hFFFFFF)), $urandom,
                           8'($urandom)));
    end
    send_item(spawn_item(32'sh1, 32'sh1, 32'sh1, 24'h1, 32'h1, 8'h1));
    send_item(op_item(OP_READ, 24'h0, 8'hFF));
    send_item(op_item(OP_TICK, 24'h008000, 8'd0));
    send_item(op_item(OP_READ, 24'h0, 8'hFF));
    send_item(op_item(OP_TICK, 24'h400000, 8'd0));
    send_item(op_item(OP_READ, 24'h0, 8'd0));
    send_item(op_item(OP_TICK, 24'hFFFFFF, 8'd0));
    send_item(op_item(OP_READ, 24'h0, 8'd0));
    drain();
    write_cfg(CFG_FADE, 1'b0);
    write_cfg(CFG_FIZZLE, 1'b0);

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
